// ===== hw/rtl/ebrt_pkg.sv =====
// shared types, constants and microcode program of the retry backoff timer
package ebrt_pkg;

    localparam int CmdW            = 2;
    localparam int TimeW           = 32;
    localparam int GrowW           = 16;
    localparam int JitW            = 16;
    localparam int FracW           = 8;
    localparam int DelayQW         = TimeW + FracW;
    localparam int ProdW           = DelayQW + GrowW;
    localparam int SpanW           = TimeW - 1;
    localparam int DivBits         = TimeW;
    localparam int DivCntW         = $clog2(DivBits + 1);
    localparam int CfgIdxW         = 3;
    localparam int CfgDataW        = 32;
    localparam int PcW             = 4;
    localparam int MaxStepsDefault = 64;

    localparam logic [TimeW-1:0] BaseReset   = 32'd1000;
    localparam logic [GrowW-1:0] GrowReset   = 16'd512;
    localparam logic [TimeW-1:0] MaxReset    = 32'd60000;
    localparam logic [JitW-1:0]  JitterReset = 16'd0;
    localparam logic [GrowW-1:0] GrowOne     = 16'd256;

    typedef enum logic [CmdW-1:0] {
        CMD_RESET   = 2'd0,
        CMD_SUCCESS = 2'd1,
        CMD_FAIL    = 2'd2,
        CMD_QUERY   = 2'd3
    } cmd_t;

    typedef enum logic [CfgIdxW-1:0] {
        REG_BASE_DELAY      = 3'd0,
        REG_GROWTH_FACTOR   = 3'd1,
        REG_MAX_DELAY       = 3'd2,
        REG_JITTER_FRACTION = 3'd3
    } cfg_idx_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_FETCH,
        OP_MUL,
        OP_GROW,
        OP_WHOLE,
        OP_SPANMUL,
        OP_SPAN,
        OP_DIV,
        OP_SUM,
        OP_JIT,
        OP_CAP,
        OP_UPDATE
    } op_t;

    typedef enum logic [3:0] {
        C_NEXT,
        C_ALWAYS,
        C_NOT_FAIL,
        C_STEPS_ZERO,
        C_GROW_MORE,
        C_NO_JITTER,
        C_SPAN_ZERO,
        C_DIV_MORE,
        C_JIT_LOW
    } cond_t;

    localparam logic [PcW-1:0] PC_FETCH   = 4'd0;
    localparam logic [PcW-1:0] PC_MUL     = 4'd1;
    localparam logic [PcW-1:0] PC_GROW    = 4'd2;
    localparam logic [PcW-1:0] PC_WHOLE   = 4'd3;
    localparam logic [PcW-1:0] PC_SPANMUL = 4'd4;
    localparam logic [PcW-1:0] PC_SPAN    = 4'd5;
    localparam logic [PcW-1:0] PC_DIV     = 4'd6;
    localparam logic [PcW-1:0] PC_SUM     = 4'd7;
    localparam logic [PcW-1:0] PC_JIT     = 4'd8;
    localparam logic [PcW-1:0] PC_CAP     = 4'd9;
    localparam logic [PcW-1:0] PC_UPDATE  = 4'd10;

    typedef struct packed {
        op_t             op;
        cond_t           cond;
        logic [PcW-1:0]  target;
    } ucode_t;

    // flags from the datapath that the sequencer branches and stalls on
    typedef struct packed {
        logic in_valid;
        logic out_busy;
        logic not_fail;
        logic steps_zero;
        logic grow_more;
        logic no_jitter;
        logic span_zero;
        logic div_more;
        logic jit_low;
    } status_t;

    typedef struct packed {
        op_t  op;
        logic fire;
    } seq_t;

    // control store
    function automatic ucode_t ucode(input logic [PcW-1:0] pc);
        ucode_t w;
        case (pc)
            PC_FETCH:   w = '{op: OP_FETCH,   cond: C_NOT_FAIL,   target: PC_UPDATE};
            PC_MUL:     w = '{op: OP_MUL,     cond: C_STEPS_ZERO, target: PC_WHOLE};
            PC_GROW:    w = '{op: OP_GROW,    cond: C_GROW_MORE,  target: PC_MUL};
            PC_WHOLE:   w = '{op: OP_WHOLE,   cond: C_NO_JITTER,  target: PC_UPDATE};
            PC_SPANMUL: w = '{op: OP_SPANMUL, cond: C_NEXT,       target: PC_FETCH};
            PC_SPAN:    w = '{op: OP_SPAN,    cond: C_SPAN_ZERO,  target: PC_UPDATE};
            PC_DIV:     w = '{op: OP_DIV,     cond: C_DIV_MORE,   target: PC_DIV};
            PC_SUM:     w = '{op: OP_SUM,     cond: C_NEXT,       target: PC_FETCH};
            PC_JIT:     w = '{op: OP_JIT,     cond: C_JIT_LOW,    target: PC_UPDATE};
            PC_CAP:     w = '{op: OP_CAP,     cond: C_NEXT,       target: PC_FETCH};
            PC_UPDATE:  w = '{op: OP_UPDATE,  cond: C_ALWAYS,     target: PC_FETCH};
            default:    w = '{op: OP_NOP,     cond: C_ALWAYS,     target: PC_FETCH};
        endcase
        return w;
    endfunction

endpackage

// ===== hw/rtl/ebrt_if.sv =====
// handshake channels of the retry backoff timer: item in, result out, config write
interface ebrt_item_if;
    logic                        valid;
    logic                        ready;
    logic [ebrt_pkg::CmdW-1:0]   command;
    logic [ebrt_pkg::TimeW-1:0]  now_ms;
    logic [ebrt_pkg::TimeW-1:0]  random_word;

    modport source (output valid, output command, output now_ms, output random_word,
                    input ready);
    modport sink   (input valid, input command, input now_ms, input random_word,
                    output ready);
endinterface

interface ebrt_result_if;
    logic                        valid;
    logic                        ready;
    logic                        can_attempt;
    logic [ebrt_pkg::TimeW-1:0]  failures;
    logic [ebrt_pkg::TimeW-1:0]  next_attempt_time;
    logic [ebrt_pkg::TimeW-1:0]  applied_delay;

    modport source (output valid, output can_attempt, output failures,
                    output next_attempt_time, output applied_delay, input ready);
    modport sink   (input valid, input can_attempt, input failures,
                    input next_attempt_time, input applied_delay, output ready);
endinterface

interface ebrt_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [ebrt_pkg::CfgIdxW-1:0]  index;
    logic [ebrt_pkg::CfgDataW-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/ebrt_sequencer.sv =====
// microcode sequencer: step counter, control store and conditional jumps
module ebrt_sequencer (
    input  logic              clk,
    input  logic              rst_n,
    input  ebrt_pkg::status_t status,
    output ebrt_pkg::seq_t    seq
);
    import ebrt_pkg::*;

    logic [PcW-1:0] pc_reg;
    logic [PcW-1:0] pc_next;
    ucode_t         uw;
    logic           stall;
    logic           take;

    assign uw = ucode(pc_reg);

    // handshake steps wait in place
    assign stall = ((uw.op == OP_FETCH) && !status.in_valid)
                || ((uw.op == OP_UPDATE) && status.out_busy);

    always_comb
    begin
        case (uw.cond)
            C_NEXT:       take = 1'b0;
            C_ALWAYS:     take = 1'b1;
            C_NOT_FAIL:   take = status.not_fail;
            C_STEPS_ZERO: take = status.steps_zero;
            C_GROW_MORE:  take = status.grow_more;
            C_NO_JITTER:  take = status.no_jitter;
            C_SPAN_ZERO:  take = status.span_zero;
            C_DIV_MORE:   take = status.div_more;
            C_JIT_LOW:    take = status.jit_low;
            default:      take = 1'b0;
        endcase
    end

    always_comb
    begin
        if (stall)
        begin
            pc_next = pc_reg;
        end
        else if (take)
        begin
            pc_next = uw.target;
        end
        else
        begin
            pc_next = pc_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= PC_FETCH;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    assign seq.op   = uw.op;
    assign seq.fire = !stall;

endmodule

// ===== hw/rtl/exponential_backoff_retry_timer.sv =====
// Retry backoff timer. One result word per item word. Reset and success clear the failure
// count and allow an attempt now; fail grows the delay from base_delay by growth_factor
// (Q8.8) once per earlier failure (at most MAX_STEPS times, stopping at the cap
// max(max_delay, base_delay)), adds symmetric jitter of random_word mod (2*span+1) - span
// and schedules now_ms + delay; query only reports. An item runs through a microcoded
// sequencer over one shared 40x16 multiplier and a one-bit-per-cycle remainder unit.
// Reset, success and query go from the fetch step straight to the update step. Fail runs
// n growth steps (n <= min(failures, MAX_STEPS), fewer once the cap is reached) and
// ends there when no jitter applies or the jitter span comes out zero; else it runs the
// remainder loop over the 32 bits of random_word, adds the jitter and caps the result,
// or gives a zero delay when the jittered delay drops to zero.
// The result sits in an output register, so the next item is taken while it waits.
// Config words are accepted at any time but must only be written while the block is idle.
module exponential_backoff_retry_timer #(
    parameter int MAX_STEPS = ebrt_pkg::MaxStepsDefault
) (
    input  logic       clk,
    input  logic       rst_n,
    ebrt_item_if.sink     item,
    ebrt_result_if.source result,
    ebrt_cfg_if.sink      cfg
);
    import ebrt_pkg::*;

    localparam int StepW = $clog2(MAX_STEPS + 1);

    // configuration registers
    logic [TimeW-1:0] base_reg;
    logic [GrowW-1:0] growth_reg;
    logic [TimeW-1:0] max_reg;
    logic [JitW-1:0]  jitter_reg;

    // architectural state
    logic [TimeW-1:0] fc_reg,        fc_next;
    logic [TimeW-1:0] next_time_reg, next_time_next;

    // item latches
    cmd_t             cmd_reg,       cmd_next;
    logic [TimeW-1:0] now_reg,       now_next;
    logic [TimeW-1:0] rnd_reg,       rnd_next;
    logic [TimeW-1:0] cap_reg,       cap_next;

    // working datapath
    logic [DelayQW-1:0] d_reg,       d_next;
    logic [StepW-1:0]   steps_reg,   steps_next;
    logic [ProdW-1:0]   prod_reg,    prod_next;
    logic [TimeW-1:0]   delay_reg,   delay_next;
    logic [SpanW-1:0]   span_reg,    span_next;
    logic [TimeW-1:0]   rem_reg,     rem_next;
    logic [TimeW-1:0]   dvd_reg,     dvd_next;
    logic [DivCntW-1:0] cnt_reg,     cnt_next;
    logic [TimeW:0]     sum_reg,     sum_next;

    // output register
    logic             res_valid_reg,   res_valid_next;
    logic             res_can_reg,     res_can_next;
    logic [TimeW-1:0] res_fail_reg,    res_fail_next;
    logic [TimeW-1:0] res_next_reg,    res_next_next;
    logic [TimeW-1:0] res_applied_reg, res_applied_next;

    status_t status;
    seq_t    seq;

    logic [TimeW-1:0]   cap_now;
    logic [GrowW-1:0]   grow_eff;
    logic [DelayQW-1:0] mul_a;
    logic [GrowW-1:0]   mul_b;
    logic [ProdW-1:0]   mul_p;
    logic [DelayQW-1:0] cap_q;
    logic [ProdW-FracW-1:0] grown;
    logic               at_cap;
    logic [TimeW-1:0]   whole;
    logic [TimeW-1:0]   span_raw;
    logic [SpanW-1:0]   span_sat;
    logic [TimeW-1:0]   divisor;
    logic [TimeW:0]     trial;
    logic               trial_ge;
    logic [TimeW-1:0]   rem_step;
    logic               jit_low;
    logic [StepW-1:0]   steps_init;
    logic [TimeW-1:0]   fc_upd;
    logic [TimeW-1:0]   next_upd;
    logic [TimeW-1:0]   applied_upd;
    logic [TimeW-1:0]   slack;

    ebrt_sequencer u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .seq    (seq)
    );

    // config port never stalls
    assign cfg.ready = 1'b1;

    assign item.ready = (seq.op == OP_FETCH);

    assign result.valid             = res_valid_reg;
    assign result.can_attempt       = res_can_reg;
    assign result.failures          = res_fail_reg;
    assign result.next_attempt_time = res_next_reg;
    assign result.applied_delay     = res_applied_reg;

    // effective cap and growth factor, zero growth behaves as 1.0
    assign cap_now  = (max_reg >= base_reg) ? max_reg : base_reg;
    assign grow_eff = (growth_reg == '0) ? GrowOne : growth_reg;

    // one multiplier shared by the growth loop and the jitter span
    assign mul_a = (seq.op == OP_MUL) ? d_reg : {{FracW{1'b0}}, delay_reg};
    assign mul_b = (seq.op == OP_MUL) ? grow_eff : jitter_reg;
    assign mul_p = ProdW'(mul_a) * ProdW'(mul_b);

    // growth step: drop fraction bits, stop at the cap
    assign cap_q  = {cap_reg, {FracW{1'b0}}};
    assign grown  = prod_reg[ProdW-1:FracW];
    assign at_cap = (grown >= (ProdW-FracW)'(cap_q));
    assign whole  = d_reg[DelayQW-1:FracW];

    // span = delay * fraction >> 16, held below 2^31
    assign span_raw = prod_reg[TimeW+JitW-1:JitW];
    assign span_sat = span_raw[TimeW-1] ? {SpanW{1'b1}} : span_raw[SpanW-1:0];

    // restoring remainder step against 2*span+1
    assign divisor  = {span_reg, 1'b1};
    assign trial    = {rem_reg, dvd_reg[TimeW-1]};
    assign trial_ge = (trial >= {1'b0, divisor});
    assign rem_step = trial_ge ? TimeW'(trial - {1'b0, divisor}) : trial[TimeW-1:0];

    assign jit_low = (sum_reg <= (TimeW+1)'(span_reg));

    assign steps_init = (fc_reg < TimeW'(MAX_STEPS)) ? StepW'(fc_reg) : StepW'(MAX_STEPS);

    // state update at the end of an item
    always_comb
    begin
        fc_upd      = fc_reg;
        next_upd    = next_time_reg;
        applied_upd = '0;
        case (cmd_reg)
            CMD_RESET, CMD_SUCCESS:
            begin
                fc_upd   = '0;
                next_upd = now_reg;
            end
            CMD_FAIL:
            begin
                applied_upd = delay_reg;
                next_upd    = now_reg + delay_reg;
                fc_upd      = (fc_reg == {TimeW{1'b1}}) ? fc_reg : fc_reg + 1'b1;
            end
            default:
            begin
                fc_upd = fc_reg;
            end
        endcase
        // wrap-safe compare: now at or after next when the difference is non-negative
        slack = now_reg - next_upd;
    end

    always_comb
    begin
        status.in_valid   = item.valid;
        status.out_busy   = res_valid_reg && !result.ready;
        status.not_fail   = (cmd_t'(item.command) != CMD_FAIL);
        status.steps_zero = (steps_reg == '0);
        status.grow_more  = !at_cap && (steps_reg != StepW'(1));
        status.no_jitter  = (jitter_reg == '0) || (whole == '0);
        status.span_zero  = (span_raw == '0);
        status.div_more   = (cnt_reg != DivCntW'(1));
        status.jit_low    = jit_low;
    end

    always_comb
    begin
        fc_next          = fc_reg;
        next_time_next   = next_time_reg;
        cmd_next         = cmd_reg;
        now_next         = now_reg;
        rnd_next         = rnd_reg;
        cap_next         = cap_reg;
        d_next           = d_reg;
        steps_next       = steps_reg;
        prod_next        = prod_reg;
        delay_next       = delay_reg;
        span_next        = span_reg;
        rem_next         = rem_reg;
        dvd_next         = dvd_reg;
        cnt_next         = cnt_reg;
        sum_next         = sum_reg;
        res_valid_next   = res_valid_reg && !result.ready;
        res_can_next     = res_can_reg;
        res_fail_next    = res_fail_reg;
        res_next_next    = res_next_reg;
        res_applied_next = res_applied_reg;

        if (seq.fire)
        begin
            case (seq.op)
                OP_FETCH:
                begin
                    cmd_next   = cmd_t'(item.command);
                    now_next   = item.now_ms;
                    rnd_next   = item.random_word;
                    cap_next   = cap_now;
                    d_next     = {base_reg, {FracW{1'b0}}};
                    steps_next = steps_init;
                end
                OP_MUL, OP_SPANMUL:
                begin
                    prod_next = mul_p;
                end
                OP_GROW:
                begin
                    d_next     = at_cap ? cap_q : grown[DelayQW-1:0];
                    steps_next = steps_reg - 1'b1;
                end
                OP_WHOLE:
                begin
                    delay_next = whole;
                end
                OP_SPAN:
                begin
                    span_next = span_sat;
                    rem_next  = '0;
                    dvd_next  = rnd_reg;
                    cnt_next  = DivCntW'(DivBits);
                end
                OP_DIV:
                begin
                    rem_next = rem_step;
                    dvd_next = {dvd_reg[TimeW-2:0], 1'b0};
                    cnt_next = cnt_reg - 1'b1;
                end
                OP_SUM:
                begin
                    sum_next = {1'b0, delay_reg} + {1'b0, rem_reg};
                end
                OP_JIT:
                begin
                    // jittered value at or below zero gives no delay
                    if (jit_low)
                    begin
                        delay_next = '0;
                    end
                    else
                    begin
                        sum_next = sum_reg - (TimeW+1)'(span_reg);
                    end
                end
                OP_CAP:
                begin
                    delay_next = (sum_reg >= {1'b0, cap_reg}) ? cap_reg : sum_reg[TimeW-1:0];
                end
                OP_UPDATE:
                begin
                    fc_next          = fc_upd;
                    next_time_next   = next_upd;
                    res_valid_next   = 1'b1;
                    res_can_next     = !slack[TimeW-1];
                    res_fail_next    = fc_upd;
                    res_next_next    = next_upd;
                    res_applied_next = applied_upd;
                end
                default:
                begin
                    prod_next = prod_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= BaseReset;
            growth_reg    <= GrowReset;
            max_reg       <= MaxReset;
            jitter_reg    <= JitterReset;
            fc_reg        <= '0;
            next_time_reg <= '0;
            steps_reg     <= '0;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                case (cfg_idx_t'(cfg.index))
                    REG_BASE_DELAY:      base_reg   <= cfg.data[TimeW-1:0];
                    REG_GROWTH_FACTOR:   growth_reg <= cfg.data[GrowW-1:0];
                    REG_MAX_DELAY:       max_reg    <= cfg.data[TimeW-1:0];
                    REG_JITTER_FRACTION: jitter_reg <= cfg.data[JitW-1:0];
                    default:             base_reg   <= base_reg;
                endcase
            end
            fc_reg        <= fc_next;
            next_time_reg <= next_time_next;
            steps_reg     <= steps_next;
            cnt_reg       <= cnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg         <= cmd_next;
        now_reg         <= now_next;
        rnd_reg         <= rnd_next;
        cap_reg         <= cap_next;
        d_reg           <= d_next;
        prod_reg        <= prod_next;
        delay_reg       <= delay_next;
        span_reg        <= span_next;
        rem_reg         <= rem_next;
        dvd_reg         <= dvd_next;
        sum_reg         <= sum_next;
        res_can_reg     <= res_can_next;
        res_fail_reg    <= res_fail_next;
        res_next_reg    <= res_next_next;
        res_applied_reg <= res_applied_next;
    end

    // a result only appears after an update step went through
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(seq.op == OP_UPDATE && seq.fire))
        else $error("result raised without update step");

    // growth counter never exceeds the step limit
    assert property (@(posedge clk) disable iff (!rst_n)
        steps_reg <= StepW'(MAX_STEPS))
        else $error("growth step count beyond limit");

    // a fail delay never exceeds the effective cap
    assert property (@(posedge clk) disable iff (!rst_n)
        (seq.op == OP_UPDATE && cmd_reg == CMD_FAIL) |-> (delay_reg <= cap_reg))
        else $error("fail delay above cap");

    // a committed fail always leaves a nonzero failure count
    assert property (@(posedge clk) disable iff (!rst_n)
        (seq.op == OP_UPDATE && seq.fire && cmd_reg == CMD_FAIL) |=> (fc_reg != '0))
        else $error("failure count zero after fail");

endmodule
